// ----- rtl/core/chacha_pkg.sv -----
// ----------------------------------------------------------------------------
// chacha_pkg
// Shared constants, register indexes and controller/datapath signal groups.
// ----------------------------------------------------------------------------
package chacha_pkg;

  localparam int ROUND_COUNT_DEF = 8;

  localparam int DATA_W     = 8;
  localparam int CFG_DATA_W = 64;
  localparam int CFG_IDX_W  = 3;
  localparam int POS_W      = 7;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_KEY_0_7   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_KEY_8_15  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_KEY_16_23 = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_KEY_24_31 = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_NONCE     = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_KEY_MODE  = 3'd5;

  // "expand 32-byte k" / "expand 16-byte k" as little-endian words
  localparam logic [31:0] CONST_W0       = 32'h6170_7865;
  localparam logic [31:0] SIGMA_W1       = 32'h3320_646E;
  localparam logic [31:0] SIGMA_W2       = 32'h7962_2D32;
  localparam logic [31:0] TAU_W1         = 32'h3120_646E;
  localparam logic [31:0] TAU_W2         = 32'h7962_2D36;
  localparam logic [31:0] CONST_W3       = 32'h6B20_6574;

  // Controller to datapath
  typedef struct packed {
    logic       load;     // load the initial state into the working words
    logic       mix;      // apply one half quarter-round step to four lanes
    logic       finish;   // add the initial state, bump counter, rewind buffer
    logic       consume;  // take one keystream byte for an accepted input
    logic [1:0] step;     // half step within a quarter round
    logic       diag;     // diagonal round when set, column round otherwise
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic empty;          // keystream buffer used up
  } status_t;

endpackage

// ----- rtl/core/chacha_if.sv -----
// ----------------------------------------------------------------------------
// chacha_if
// Valid/ready byte channels for message input and result output.
// ----------------------------------------------------------------------------
interface chacha_in_if;
  logic                          valid;
  logic                          ready;
  logic [chacha_pkg::DATA_W-1:0] data_in;

  modport source (output valid, output data_in, input ready);
  modport sink   (input valid, input data_in, output ready);
endinterface

interface chacha_out_if;
  logic                          valid;
  logic                          ready;
  logic [chacha_pkg::DATA_W-1:0] data_out;

  modport source (output valid, output data_out, input ready);
  modport sink   (input valid, input data_out, output ready);
endinterface

// ----- rtl/core/chacha_ctrl.sv -----
// ----------------------------------------------------------------------------
// chacha_ctrl
// Sequencer for block refill and byte transfer handshakes.
// ----------------------------------------------------------------------------
module chacha_ctrl #(
  parameter int ROUND_COUNT = chacha_pkg::ROUND_COUNT_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  output logic                out_valid,
  input  logic                out_ready,
  input  logic                cfg_we,
  input  chacha_pkg::status_t status,
  output chacha_pkg::cmd_t    cmd
);
  import chacha_pkg::*;

  localparam int STEPS = ((ROUND_COUNT + 1) / 2) * 8;
  localparam int CNT_W = $clog2(STEPS);

  typedef enum logic [1:0] {
    IDLE,
    ROUND,
    FINISH
  } state_t;

  state_t           state;
  logic [CNT_W-1:0] cnt;
  logic             accept;

  assign in_ready = (state == IDLE) && !status.empty && !cfg_we &&
                    (!out_valid || out_ready);
  assign accept   = in_valid && in_ready;

  always_comb begin
    cmd         = '0;
    cmd.load    = (state == IDLE) && status.empty && in_valid && !cfg_we;
    cmd.mix     = (state == ROUND) && !cfg_we;
    cmd.finish  = (state == FINISH) && !cfg_we;
    cmd.consume = accept;
    cmd.step    = cnt[1:0];
    cmd.diag    = cnt[2];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= IDLE;
      cnt       <= '0;
      out_valid <= 1'b0;
    end else begin
      if (accept) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        IDLE: begin
          if (cmd.load) begin
            state <= ROUND;
            cnt   <= '0;
          end
        end
        ROUND: begin
          if (cfg_we) begin
            state <= IDLE;
          end else begin
            cnt <= cnt + CNT_W'(1);
            if (cnt == CNT_W'(STEPS - 1)) begin
              state <= FINISH;
            end
          end
        end
        FINISH: begin
          state <= IDLE;
        end
        default: begin
          state <= IDLE;
        end
      endcase
    end
  end

endmodule

// ----- rtl/core/chacha_dp.sv -----
// ----------------------------------------------------------------------------
// chacha_dp
// Key registers, block counter, 16-word working state and keystream readout.
// ----------------------------------------------------------------------------
module chacha_dp (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_we,
  input  logic [chacha_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [chacha_pkg::CFG_DATA_W-1:0]   cfg_data,
  input  chacha_pkg::cmd_t                    cmd,
  output chacha_pkg::status_t                 status,
  input  logic [chacha_pkg::DATA_W-1:0]       data_in,
  output logic [chacha_pkg::DATA_W-1:0]       data_out
);
  import chacha_pkg::*;

  logic [63:0]      key [4];
  logic [63:0]      nonce;
  logic             mode;
  logic [63:0]      counter;
  logic [POS_W-1:0] pos;
  logic [31:0]      w      [16];
  logic [31:0]      w_next [16];
  logic [31:0]      init   [16];
  logic [63:0]      k2;
  logic [63:0]      k3;
  logic [31:0]      word;
  logic [7:0]       ks_byte;
  logic             cfg_hit;

  function automatic logic [31:0] step_rot(input logic [31:0] v, input logic [1:0] step);
    logic [31:0] r;
    case (step)
      2'd0:    r = {v[15:0], v[31:16]};
      2'd1:    r = {v[19:0], v[31:20]};
      2'd2:    r = {v[23:0], v[31:24]};
      default: r = {v[24:0], v[31:25]};
    endcase
    return r;
  endfunction

  assign cfg_hit      = cfg_we && (cfg_index <= REG_KEY_MODE);
  assign status.empty = pos[POS_W-1];

  // Initial block state from the registers and the current counter
  always_comb begin
    k2       = mode ? key[2] : key[0];
    k3       = mode ? key[3] : key[1];
    init[0]  = CONST_W0;
    init[1]  = mode ? SIGMA_W1 : TAU_W1;
    init[2]  = mode ? SIGMA_W2 : TAU_W2;
    init[3]  = CONST_W3;
    init[4]  = key[0][31:0];
    init[5]  = key[0][63:32];
    init[6]  = key[1][31:0];
    init[7]  = key[1][63:32];
    init[8]  = k2[31:0];
    init[9]  = k2[63:32];
    init[10] = k3[31:0];
    init[11] = k3[63:32];
    init[12] = counter[31:0];
    init[13] = counter[63:32];
    init[14] = nonce[31:0];
    init[15] = nonce[63:32];
  end

  // One half step of four independent quarter rounds
  always_comb begin
    logic [3:0]  ia, ib, ic, id;
    logic [3:0]  xi, yi, zi;
    logic [31:0] xs;
    for (int i = 0; i < 16; i++) begin
      w_next[i] = w[i];
    end
    for (int q = 0; q < 4; q++) begin
      ia = 4'(q);
      ib = cmd.diag ? 4'(4 + ((q + 1) % 4))  : 4'(4 + q);
      ic = cmd.diag ? 4'(8 + ((q + 2) % 4))  : 4'(8 + q);
      id = cmd.diag ? 4'(12 + ((q + 3) % 4)) : 4'(12 + q);
      xi = cmd.step[0] ? ic : ia;
      yi = cmd.step[0] ? id : ib;
      zi = cmd.step[0] ? ib : id;
      xs = w[xi] + w[yi];
      w_next[xi] = xs;
      w_next[zi] = step_rot(w[zi] ^ xs, cmd.step);
    end
  end

  assign word    = w[pos[5:2]];
  assign ks_byte = word[{pos[1:0], 3'b000} +: 8];

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      key[0] <= '0;
      key[1] <= '0;
      key[2] <= '0;
      key[3] <= '0;
      nonce  <= '0;
      mode   <= 1'b1;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_KEY_0_7:   key[0] <= cfg_data;
        REG_KEY_8_15:  key[1] <= cfg_data;
        REG_KEY_16_23: key[2] <= cfg_data;
        REG_KEY_24_31: key[3] <= cfg_data;
        REG_NONCE:     nonce  <= cfg_data;
        REG_KEY_MODE:  mode   <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // Counter and buffer position
  always_ff @(posedge clk) begin
    if (rst) begin
      counter <= '0;
      pos     <= POS_W'(64);
    end else if (cfg_hit) begin
      counter <= '0;
      pos     <= POS_W'(64);
    end else if (cmd.finish) begin
      counter <= counter + 64'd1;
      pos     <= '0;
    end else if (cmd.consume) begin
      pos     <= pos + POS_W'(1);
    end
  end

  // Working state: load, mix, then final add turns it into the keystream block
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      w <= init;
    end else if (cmd.mix) begin
      w <= w_next;
    end else if (cmd.finish) begin
      for (int i = 0; i < 16; i++) begin
        w[i] <= w[i] + init[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.consume) begin
      data_out <= data_in ^ ks_byte;
    end
  end

  a_consume_full: assert property (@(posedge clk) disable iff (rst)
    cmd.consume |-> !pos[POS_W-1])
    else $error("byte taken from an empty keystream buffer");

  a_consume_adv: assert property (@(posedge clk) disable iff (rst)
    (cmd.consume && !cfg_hit) |=> (pos == $past(pos) + POS_W'(1)))
    else $error("buffer position did not advance on transfer");

  a_finish_rewind: assert property (@(posedge clk) disable iff (rst)
    (cmd.finish && !cfg_hit) |=> (pos == '0 && counter == $past(counter) + 64'd1))
    else $error("refill did not rewind buffer and bump counter");

  a_cfg_clear: assert property (@(posedge clk) disable iff (rst)
    cfg_hit |=> (pos == POS_W'(64) && counter == '0))
    else $error("register write did not restart the keystream");

endmodule

// ----- rtl/core/chacha8_stream_xor.sv -----
// ----------------------------------------------------------------------------
// chacha8_stream_xor
// ChaCha stream cipher: each message byte is XORed with the next keystream byte.
// ----------------------------------------------------------------------------
// Each transfer on the input channel yields exactly one transfer on the output
// channel carrying data_in XOR the next keystream byte. Keystream is produced
// in 64-byte blocks from the key, nonce and a 64-bit block counter; after
// reset, or after any write to a known register, the counter is zero and the
// buffer is empty. While the buffer holds bytes and the output side does not
// stall, one byte is taken per cycle and a result sits in the output register
// while the next byte is accepted. When the buffer is used up, the byte waiting
// at the input stalls for a refill: the state is loaded, the four-lane mixing
// unit applies each half quarter-round step in turn, then the final add is
// done. Configuration writes go through cfg_we, cfg_index and cfg_data, one
// register per cycle, with no read-back; write only while no result is
// outstanding.
// ----------------------------------------------------------------------------
module chacha8_stream_xor #(
  parameter int ROUND_COUNT = chacha_pkg::ROUND_COUNT_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  chacha_in_if.sink                         in_ch,
  chacha_out_if.source                      out_ch,
  input  logic                              cfg_we,
  input  logic [chacha_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [chacha_pkg::CFG_DATA_W-1:0] cfg_data
);
  import chacha_pkg::*;

  cmd_t    cmd;
  status_t status;

  // Sequencer: owns the handshakes and the round step count
  chacha_ctrl #(
    .ROUND_COUNT (ROUND_COUNT)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .cfg_we    (cfg_we),
    .status    (status),
    .cmd       (cmd)
  );

  // Datapath: registers, block state and the output byte register
  chacha_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cmd       (cmd),
    .status    (status),
    .data_in   (in_ch.data_in),
    .data_out  (out_ch.data_out)
  );

endmodule

// ----- dv/chacha8_stream_xor_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// chacha8_stream_xor_tb
// Self-checking bench for the ChaCha byte-stream XOR block. Bytes go in on the
// input channel and come back XORed with keystream. A local ChaCha model with
// its own key, nonce, mode and block counter predicts every output byte but
// those the directed table types in. The run has a short directed table, then
// random bursts between reconfigurations, with random idling on both channels.
// ----------------------------------------------------------------------------
module chacha8_stream_xor_tb;
  import chacha_pkg::*;

  localparam int ROUNDS      = ROUND_COUNT_DEF;
  localparam int RAND_ITEMS  = 1530;  // random bytes after the directed table
  localparam int QUIET_TAIL  = 220;   // bursts begun in this tail: no idling
  localparam int STALL_LIMIT = 2000;  // cycles with no transfer before giving up
  localparam int DRAIN_TAIL  = 60;    // settle time once the last byte is back

  // Indexes outside the register map; writes to them must change nothing.
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_6 = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_7 = 3'd7;

  typedef enum logic { ROW_WRITE, ROW_BYTE } row_kind_t;

  typedef struct {
    row_kind_t             kind;
    logic [CFG_IDX_W-1:0]  idx;
    logic [CFG_DATA_W-1:0] value;
    logic [DATA_W-1:0]     data;
    bit                    typed;  // use 'want' instead of the model's byte
    logic [DATA_W-1:0]     want;
  } row_t;

  logic                  clk;
  logic                  rst = 1'b1;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic                  sink_ready = 1'b0;

  chacha_in_if  in_if ();
  chacha_out_if out_if ();

  assign out_if.ready = sink_ready;

  chacha8_stream_xor #(
    .ROUND_COUNT (ROUNDS)
  ) i_dut (
    .clk       (clk),
    .rst       (rst),
    .in_ch     (in_if),
    .out_ch    (out_if),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // --------------------------------------------------------------------------
  // Keystream model. Holds a private copy of the register file and of the
  // buffer/counter state; advanced once per accepted input byte and once per
  // register write, in the same order the block sees them.
  // --------------------------------------------------------------------------
  logic [63:0]       key_reg [4] = '{default: '0};
  logic [63:0]       nonce_reg = '0;
  logic              mode_256 = 1'b1;
  logic [DATA_W-1:0] ks_buf [64] = '{default: '0};
  int                ks_pos = 64;  // 64 means used up: refill before next byte
  logic [63:0]       blk_ctr = '0;
  logic [31:0]       mix_w [16];

  logic [DATA_W-1:0] bytes_due [$];  // expected data_out, oldest first
  int                n_fail = 0;
  bit                src_idle = 1'b1;
  bit                snk_idle = 1'b1;

  function automatic logic [31:0] rotl(logic [31:0] v, int n);
    return (v << n) | (v >> (32 - n));
  endfunction

  function automatic void quarter(int a, int b, int c, int d);
    mix_w[a] = mix_w[a] + mix_w[b]; mix_w[d] = rotl(mix_w[d] ^ mix_w[a], 16);
    mix_w[c] = mix_w[c] + mix_w[d]; mix_w[b] = rotl(mix_w[b] ^ mix_w[c], 12);
    mix_w[a] = mix_w[a] + mix_w[b]; mix_w[d] = rotl(mix_w[d] ^ mix_w[a], 8);
    mix_w[c] = mix_w[c] + mix_w[d]; mix_w[b] = rotl(mix_w[b] ^ mix_w[c], 7);
  endfunction

  // Build the next 64 keystream bytes, then bump the 64-bit block counter.
  function automatic void refill_keystream();
    logic [31:0] init [16];
    logic [63:0] k2;
    logic [63:0] k3;
    logic [31:0] sum;
    int          dr;
    int          i;
    // 128-bit mode repeats key bytes 0..15 in words 8..11
    k2 = mode_256 ? key_reg[2] : key_reg[0];
    k3 = mode_256 ? key_reg[3] : key_reg[1];
    init[0]  = CONST_W0;
    init[1]  = mode_256 ? SIGMA_W1 : TAU_W1;
    init[2]  = mode_256 ? SIGMA_W2 : TAU_W2;
    init[3]  = CONST_W3;
    init[4]  = key_reg[0][31:0];
    init[5]  = key_reg[0][63:32];
    init[6]  = key_reg[1][31:0];
    init[7]  = key_reg[1][63:32];
    init[8]  = k2[31:0];
    init[9]  = k2[63:32];
    init[10] = k3[31:0];
    init[11] = k3[63:32];
    init[12] = blk_ctr[31:0];
    init[13] = blk_ctr[63:32];
    init[14] = nonce_reg[31:0];
    init[15] = nonce_reg[63:32];
    for (i = 0; i < 16; i++) mix_w[i] = init[i];
    for (dr = 0; dr < (ROUNDS + 1) / 2; dr++) begin
      quarter(0, 4, 8, 12);
      quarter(1, 5, 9, 13);
      quarter(2, 6, 10, 14);
      quarter(3, 7, 11, 15);
      quarter(0, 5, 10, 15);
      quarter(1, 6, 11, 12);
      quarter(2, 7, 8, 13);
      quarter(3, 4, 9, 14);
    end
    for (i = 0; i < 16; i++) begin
      sum = mix_w[i] + init[i];
      ks_buf[4*i]   = sum[7:0];
      ks_buf[4*i+1] = sum[15:8];
      ks_buf[4*i+2] = sum[23:16];
      ks_buf[4*i+3] = sum[31:24];
    end
    blk_ctr = blk_ctr + 64'd1;
    ks_pos  = 0;
  endfunction

  function automatic logic [DATA_W-1:0] cipher_byte(logic [DATA_W-1:0] b);
    logic [DATA_W-1:0] r;
    if (ks_pos >= 64) refill_keystream();
    r = b ^ ks_buf[ks_pos];
    ks_pos++;
    return r;
  endfunction

  // Any known index restarts the stream at counter zero; spare indexes do not.
  function automatic void apply_reg_write(logic [CFG_IDX_W-1:0] idx,
                                          logic [CFG_DATA_W-1:0] val);
    case (idx)
      REG_KEY_0_7:   key_reg[0] = val;
      REG_KEY_8_15:  key_reg[1] = val;
      REG_KEY_16_23: key_reg[2] = val;
      REG_KEY_24_31: key_reg[3] = val;
      REG_NONCE:     nonce_reg = val;
      REG_KEY_MODE:  mode_256 = val[0];
      default:       return;
    endcase
    blk_ctr = '0;
    ks_pos  = 64;
  endfunction

  // --------------------------------------------------------------------------
  // Output side: stall in random bursts, check every transfer against the
  // oldest outstanding byte.
  // --------------------------------------------------------------------------
  int sink_hold = 0;

  always @(posedge clk) begin : out_side
    logic [DATA_W-1:0] want;
    if (rst) begin
      sink_ready <= 1'b0;
      sink_hold  <= 0;
    end else begin
      if (out_if.valid && sink_ready) begin
        if (bytes_due.size() == 0) begin
          $error("data_out transfer with nothing outstanding: got %02h", out_if.data_out);
          n_fail++;
        end else begin
          want = bytes_due.pop_front();
          if (out_if.data_out !== want) begin
            $error("data_out mismatch: expected %02h, got %02h", want, out_if.data_out);
            n_fail++;
          end
        end
      end
      // hold ready low for the rest of a burst, or maybe start a new one
      if (sink_hold != 0) begin
        sink_hold  <= sink_hold - 1;
        sink_ready <= (sink_hold == 1);
      end else if (snk_idle && $urandom_range(0, 11) == 0) begin
        sink_hold  <= $urandom_range(1, 18);
        sink_ready <= 1'b0;
      end else begin
        sink_ready <= 1'b1;
      end
    end
  end

  // Watchdog: any transfer or register write proves progress.
  int quiet_cycles = 0;

  always @(posedge clk) begin
    if (rst || (in_if.valid && in_if.ready) || (out_if.valid && sink_ready) || cfg_we) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("chacha8_stream_xor_tb NOT OK");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // --------------------------------------------------------------------------
  // Input side
  // --------------------------------------------------------------------------

  // Offer one byte, maybe after an idle burst; return on the edge of its
  // transfer with valid still high, so back-to-back bytes never toggle it.
  task automatic send_byte(input logic [DATA_W-1:0] b, input bit typed,
                           input logic [DATA_W-1:0] typed_val);
    logic [DATA_W-1:0] predicted;
    if (src_idle && $urandom_range(0, 7) == 0) begin
      in_if.valid <= 1'b0;
      repeat ($urandom_range(1, 18)) @(posedge clk);
    end
    in_if.valid   <= 1'b1;
    in_if.data_in <= b;
    do @(posedge clk); while (!in_if.ready);
    // advance the model even when the expected byte is typed in
    predicted = cipher_byte(b);
    bytes_due.push_back(typed ? typed_val : predicted);
  endtask

  // Drop valid and hold until every outstanding byte has come back.
  task automatic drain();
    in_if.valid <= 1'b0;
    do @(posedge clk); while (bytes_due.size() != 0);
  endtask

  // Register writes only go in while the block has nothing in flight.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] val);
    drain();
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    apply_reg_write(idx, val);
  endtask

  // Random register value, biased toward the all-zero and all-one extremes.
  function automatic logic [CFG_DATA_W-1:0] reg_value();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return '1;
      default: return {$urandom(), $urandom()};
    endcase
  endfunction

  // Directed table builders
  row_t plan [$];

  function automatic void plan_write(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    row_t r;
    r = '{kind: ROW_WRITE, idx: idx, value: val, data: '0, typed: 1'b0, want: '0};
    plan.push_back(r);
  endfunction

  function automatic void plan_byte(logic [DATA_W-1:0] d, bit typed = 1'b0,
                                    logic [DATA_W-1:0] want = '0);
    row_t r;
    r = '{kind: ROW_BYTE, idx: '0, value: '0, data: d, typed: typed, want: want};
    plan.push_back(r);
  endfunction

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin : stimulus
    logic [CFG_IDX_W-1:0] reg_pick [8];
    logic [DATA_W-1:0]    b;
    int                   n_random;
    int                   len;
    int                   k;
    bit                   tail;

    reg_pick = '{REG_KEY_0_7, REG_KEY_8_15, REG_KEY_16_23, REG_KEY_24_31,
                 REG_NONCE, REG_KEY_MODE, REG_SPARE_6, REG_SPARE_7};
    in_if.valid   <= 1'b0;
    in_if.data_in <= '0;

    // After reset: all-zero key and nonce, 256-bit mode, counter zero. With
    // zero input the output is the first keystream block of that setup.
    plan_byte(8'h00, 1'b1, 8'h3E);
    plan_byte(8'h00, 1'b1, 8'h00);
    plan_byte(8'h00, 1'b1, 8'hEF);
    plan_byte(8'h00, 1'b1, 8'h2F);
    plan_byte(8'h00, 1'b1, 8'h89);
    plan_byte(8'h00, 1'b1, 8'h5F);
    plan_byte(8'h00, 1'b1, 8'h40);
    plan_byte(8'h00, 1'b1, 8'hD6);
    plan_byte(8'hFF);
    plan_byte(8'h80);
    plan_byte(8'h01);
    // Writes to unmapped indexes must leave the stream where it was
    plan_write(REG_SPARE_6, '1);
    plan_byte(8'h55);
    plan_write(REG_SPARE_7, '0);
    plan_byte(8'hAA);
    // 128-bit mode: only bit 0 of the mode value counts
    plan_write(REG_KEY_MODE, 64'hFFFF_FFFF_FFFF_FFFE);
    plan_write(REG_KEY_0_7, '1);
    plan_write(REG_KEY_8_15, 64'h0123_4567_89AB_CDEF);
    plan_byte(8'h00);
    plan_byte(8'hFF);
    plan_byte(8'h7F);
    // upper key halves are ignored in 128-bit mode but still restart the stream
    plan_write(REG_KEY_16_23, '1);
    plan_write(REG_KEY_24_31, '1);
    plan_byte(8'h00);
    plan_write(REG_NONCE, '1);
    plan_byte(8'hFE);
    // back to 256-bit mode with every upper bit of the mode value set
    plan_write(REG_KEY_MODE, '1);
    plan_byte(8'h00);
    plan_byte(8'hFF);
    plan_write(REG_NONCE, '0);
    plan_write(REG_KEY_0_7, '0);
    plan_write(REG_KEY_8_15, '1);
    plan_byte(8'h12);

    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (plan[i]) begin
      if (plan[i].kind == ROW_WRITE) begin
        write_reg(plan[i].idx, plan[i].value);
      end else begin
        send_byte(plan[i].data, plan[i].typed, plan[i].want);
      end
    end

    // Random bursts. Most bursts cross one or more block boundaries; short
    // ones land writes at odd buffer positions.
    n_random = 0;
    while (n_random < RAND_ITEMS) begin
      tail = (RAND_ITEMS - n_random) <= QUIET_TAIL;
      if ($urandom_range(0, 3) != 0) begin
        repeat ($urandom_range(1, 6)) write_reg(reg_pick[$urandom_range(0, 7)], reg_value());
      end
      len = ($urandom_range(0, 4) == 0) ? $urandom_range(1, 20) : $urandom_range(64, 256);
      if (len > RAND_ITEMS - n_random) len = RAND_ITEMS - n_random;
      // give each burst its own idling mix, some with none on either side
      src_idle = !tail && ($urandom_range(0, 3) != 0);
      snk_idle = !tail && ($urandom_range(0, 3) != 0);
      for (k = 0; k < len; k++) begin
        case ($urandom_range(0, 9))
          0:       b = 8'h00;
          1:       b = 8'hFF;
          default: b = DATA_W'($urandom_range(0, 255));
        endcase
        send_byte(b, 1'b0, '0);
        n_random++;
        // now and then hold off until the output side has caught up
        if (!tail && $urandom_range(0, 249) == 0) drain();
      end
      if (tail) begin
        src_idle = 1'b0;
        snk_idle = 1'b0;
      end
    end

    in_if.valid <= 1'b0;
    do @(posedge clk); while (bytes_due.size() != 0);
    // catch any stray transfer after the last expected byte
    repeat (DRAIN_TAIL) @(posedge clk);

    if (n_fail == 0) begin
      $display("chacha8_stream_xor_tb OK");
    end else begin
      $display("chacha8_stream_xor_tb NOT OK");
    end
    $finish;
  end

endmodule
